/* rtl/mme_pkg.sv */
// Shared constants and sequencer state type for the modular exponentiation block.
package mme_pkg;

    // Default operand width for base, exponent, modulus and result
    localparam int OPERAND_WIDTH_DEF = 32;

    // Square-and-multiply sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_OUT
    } mme_state_t;

endpackage

/* rtl/modular_exponentiation_top.sv */
// Top level: right-to-left square-and-multiply sequencer around a bit-serial modular multiplier.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+-----------------
//  input   | in        | s_base_value, s_exponent, s_modulus            | s_valid/s_ready
//  result  | out       | m_power_result                                 | m_valid/m_ready
//
// One item at a time. Zero exponent or zero modulus: the result goes straight to the output state.
// Otherwise: the base is reduced first, then the multiplications run in the
// shared bit-serial multiplier (one per set exponent bit, one squaring per bit below the
// top set bit), and the result is then handed over to the output register.
// Reset (aresetn, synchronous) returns the sequencer to idle and drops any pending result.
// s_ready is high whenever the sequencer is idle, also while a result waits on m_ready;
// a finished result waits in its state until the output register is free.
module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = mme_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OPERAND_WIDTH-1:0] s_base_value,
    input  logic [OPERAND_WIDTH-1:0] s_exponent,
    input  logic [OPERAND_WIDTH-1:0] s_modulus,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OPERAND_WIDTH-1:0] m_power_result
);
    import mme_pkg::*;

    localparam int W = OPERAND_WIDTH;

    mme_state_t   state_reg, state_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] mod_reg, mod_next;
    logic         m_valid_reg, m_valid_next;
    logic [W-1:0] m_power_result_reg, m_power_result_next;

    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_m;
    logic         mm_done;
    logic [W-1:0] mm_result;

    mme_serial_mulmod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (mm_m),
        .done    (mm_done),
        .result  (mm_result)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence the exponent scan and drive the multiplier
    always_comb begin
        state_next          = state_reg;
        acc_next            = acc_reg;
        sq_next             = sq_reg;
        exp_next            = exp_reg;
        mod_next            = mod_reg;
        m_valid_next        = m_valid_reg;
        m_power_result_next = m_power_result_reg;
        mm_start            = 1'b0;
        mm_a                = sq_reg;
        mm_b                = sq_reg;
        mm_m                = mod_reg;

        // Drop the held result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    exp_next = s_exponent;
                    mod_next = s_modulus;
                    if (s_exponent == '0) begin
                        acc_next   = W'(1);
                        state_next = ST_OUT;
                    end else if (s_modulus == '0) begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        // Reduce the base: multiply 1 by the unreduced base, bit by bit
                        acc_next   = (s_modulus == W'(1)) ? '0 : W'(1);
                        mm_start   = 1'b1;
                        mm_a       = W'(1);
                        mm_b       = s_base_value;
                        mm_m       = s_modulus;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_done) begin
                    sq_next    = mm_result;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (exp_reg == '0) begin
                    state_next = ST_OUT;
                end else if (exp_reg[0]) begin
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = sq_reg;
                    state_next = ST_MUL;
                end else begin
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL: begin
                // Fold the square into the accumulator and clear the bit just used
                if (mm_done) begin
                    acc_next    = mm_result;
                    exp_next    = {exp_reg[W-1:1], 1'b0};
                    state_next  = ST_NEXT;
                end
            end
            ST_SQR: begin
                if (mm_done) begin
                    sq_next    = mm_result;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = ST_NEXT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_power_result_next = acc_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg            <= acc_next;
        sq_reg             <= sq_next;
        exp_reg            <= exp_next;
        mod_reg            <= mod_next;
        m_power_result_reg <= m_power_result_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

    // Multiplier completes only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiplier done outside a wait state");

    // Accumulator and running square stay reduced between multiplications
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT) |-> (acc_reg < mod_reg && sq_reg < mod_reg))
        else $error("operand not reduced below modulus");

    // A free output register is filled in the cycle after the result is ready
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into free output register");

    // New multiplication is only launched while no other is in flight
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> (state_reg == ST_IDLE || state_reg == ST_NEXT))
        else $error("multiplier started while busy");

endmodule

/* rtl/mme_serial_mulmod.sv */
// Bit-serial modular multiplier: one bit of the multiplier operand per cycle, MSB first.
module mme_serial_mulmod #(
    parameter int OPERAND_WIDTH = mme_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] op_a,
    input  logic [OPERAND_WIDTH-1:0] op_b,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] result
);
    import mme_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = OPERAND_WIDTH + 2;
    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW-1:0] sum;
    logic [DW-1:0] m_once;
    logic [DW-1:0] m_twice;
    logic [W-1:0]  step_value;

    // Double the partial result and add the multiplicand on a set bit; reduce by m or 2m
    always_comb begin
        sum     = {1'b0, acc_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : {DW{1'b0}});
        m_once  = {2'b00, m_reg};
        m_twice = {1'b0, m_reg, 1'b0};
        if (sum >= m_twice) begin
            step_value = W'(sum - m_twice);
        end else if (sum >= m_once) begin
            step_value = W'(sum - m_once);
        end else begin
            step_value = W'(sum);
        end
    end

    // Load operands on start, then advance one multiplier bit per cycle
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = step_value;
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the square-and-multiply modular exponentiation block.
`timescale 1ns / 1ps

module tb_top;

    localparam int W           = mme_pkg::OPERAND_WIDTH_DEF;
    localparam int RANDOM_REQS = 280;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 8000;
    localparam int DRAIN       = 20;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [W-1:0] base_v;
        logic [W-1:0] expo;
        logic [W-1:0] modulus;
    } power_req_t;

    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [W-1:0] s_base_value = '0;
    logic [W-1:0] s_exponent   = '0;
    logic [W-1:0] s_modulus    = '1;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [W-1:0] m_power_result;

    power_req_t   pending_reqs[$];
    logic [W-1:0] expected_powers[$];

    int unsigned  total_reqs     = 0;
    int unsigned  reqs_accepted  = 0;
    int unsigned  results_seen   = 0;
    int unsigned  error_count    = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  tx_gap         = 0;
    int unsigned  rx_wait        = 0;
    int unsigned  hold_left      = 0;
    bit           hold_done      = 1'b0;

    modular_exponentiation_top #(
        .OPERAND_WIDTH(W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_value  (s_base_value),
        .s_exponent    (s_exponent),
        .s_modulus     (s_modulus),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    // Free-running clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Right-to-left square and multiply at double width
    function automatic logic [W-1:0] mod_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                               input logic [W-1:0] m);
        logic [2*W-1:0] acc;
        logic [2*W-1:0] sq;
        logic [2*W-1:0] m_wide;
        int             i;
        if (e == '0) return W'(1);
        if (m == '0) return '0;
        m_wide = {{W{1'b0}}, m};
        acc    = (m == W'(1)) ? '0 : (2*W)'(1);
        sq     = {{W{1'b0}}, b} % m_wide;
        for (i = 0; i < W; i++) begin
            if (e[i]) acc = (acc * sq) % m_wide;
            sq = (sq * sq) % m_wide;
        end
        return acc[W-1:0];
    endfunction

    // Mostly short gaps, a few long ones, none at all in quiet stretches
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 24);
        return $urandom_range(60, 300);
    endfunction

    function automatic bit quiet_phase(input int unsigned n);
        return ((n / 25) % 4) == 3;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_req(input logic [W-1:0] b, input logic [W-1:0] e,
                           input logic [W-1:0] m);
        power_req_t r;
        r.base_v  = b;
        r.expo    = e;
        r.modulus = m;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // Driver: present the next pending item once the current one is taken
    always @(posedge aclk) begin : tx_side
        power_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_powers.push_back(mod_power(s_base_value, s_exponent, s_modulus));
                reqs_accepted <= reqs_accepted + 1;
            end
            if (tx_gap != 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_base_value <= r.base_v;
                s_exponent   <= r.expo;
                s_modulus    <= r.modulus;
                s_valid      <= 1'b1;
                tx_gap       <= pick_gap(quiet_phase(reqs_accepted));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, then stall at random
    always @(posedge aclk) begin : rx_side
        logic [W-1:0] want;
        int unsigned  stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_powers.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", m_power_result));
            end else begin
                want = expected_powers.pop_front();
                if (m_power_result !== want)
                    report_mismatch($sformatf("result %0d: power_result %h, expected %h",
                                              results_seen, m_power_result, want));
            end
            results_seen <= results_seen + 1;
            stall = pick_gap(quiet_phase(results_seen));
            rx_wait <= stall;
            m_ready <= (stall == 0) && (hold_left == 0);
        end else begin
            // count the stall down only while a result is waiting
            if (rx_wait != 0 && m_valid) rx_wait <= rx_wait - 1;
            m_ready <= (hold_left == 0) && (rx_wait == 0);
        end
    end

    // Hold the result side off once for long enough to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** modular_exponentiation_top: FAILED **");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        int unsigned  kind;
        int unsigned  k;

        // zero exponent, including modulus one and modulus zero
        add_req(32'd5, '0, 32'd7);
        add_req('0, '0, 32'd1);
        add_req(32'd123, '0, '0);
        add_req('1, '0, '1);
        // zero modulus with a nonzero exponent
        add_req(32'd7, 32'd5, '0);
        add_req('1, 32'd1, '0);
        // field extremes
        add_req('0, 32'd5, 32'd13);
        add_req('1, '1, '1);
        add_req(32'hFFFF_FFFE, '1, '1);
        add_req(32'd2, 32'd10, 32'd1);
        add_req(32'd1, '1, 32'd97);
        add_req('1, 32'd2, 32'd2);
        add_req(32'd2, 32'd1, 32'h8000_0000);
        // unreduced base
        add_req('1, 32'd3, 32'd1000);
        add_req(32'd12345, 32'd1, 32'd100);
        // single top exponent bit, all exponent bits, alternating patterns
        add_req(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
        add_req(32'hDEAD_BEEF, '1, 32'hFFFF_FFFB);
        add_req(32'd2, 32'd31, '1);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);

        // random mix, biased towards short exponents to keep the run short
        repeat (RANDOM_REQS) begin
            kind = $urandom_range(0, 9);
            b    = $urandom;
            e    = $urandom;
            m    = $urandom;
            if (kind >= 5 && kind <= 6) begin
                e = $urandom_range(0, 255);
                m = m >> $urandom_range(0, 31);
            end else if (kind == 7) begin
                m = $urandom_range(1, 16);
            end else if (kind == 8) begin
                k = $urandom_range(0, W - 1);
                e = W'(1) << k;
                if ($urandom_range(0, 1)) e = e | (e - 1);
            end else if (kind == 9) begin
                e = '0;
            end
            if (m == '0) m = W'(1);
            add_req(b, e, m);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        wait (reqs_accepted == total_reqs && results_seen == reqs_accepted);
        repeat (DRAIN) @(posedge aclk);
        if (expected_powers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_powers.size()));

        if (error_count == 0) begin
            $display("** modular_exponentiation_top: PASSED **");
        end else begin
            $display("** modular_exponentiation_top: FAILED **");
        end
        $finish;
    end

endmodule
